// ===== rtl/core/flps_pkg.sv =====
// ---------------------------------------------------------------------------
// flps_pkg - shared definitions for the flight phase peak statistics block
// Phase, action and record codes, config indices, last field indices, widths,
// extreme values and a saturating magnitude function.
package flps_pkg;

  localparam int TIME_BITS = 32;
  localparam int VAL_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LIFTOFF = 3'd1,
    PH_ASCEND  = 3'd2,
    PH_DROGUE  = 3'd3,
    PH_MAIN    = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_LIFTOFF    = 4'd1,
    ACT_APOGEE     = 4'd2,
    ACT_DEPLOY_ALT = 4'd3,
    ACT_FILT_PRESS = 4'd4,
    ACT_FILT_ALT   = 4'd5,
    ACT_BARO_PAIR  = 4'd6,
    ACT_ACCEL_Z    = 4'd7,
    ACT_GPS        = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    REC_LIFTOFF = 2'd0,
    REC_APOGEE  = 2'd1,
    REC_DROGUE  = 2'd2,
    REC_MAIN    = 2'd3
  } rec_kind_t;

  localparam logic [1:0] CFG_LIFTOFF_TO = 2'd0;
  localparam logic [1:0] CFG_DROGUE_TO  = 2'd1;
  localparam logic [1:0] CFG_MAIN_TO    = 2'd2;

  // last field index of each record
  localparam logic [2:0] LAST_LIFTOFF = 3'd5;
  localparam logic [2:0] LAST_APOGEE  = 3'd7;
  localparam logic [2:0] LAST_DROGUE  = 3'd1;
  localparam logic [2:0] LAST_MAIN    = 3'd3;

  function automatic logic signed [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] res;
    if (!x[VAL_W-1]) res = x;
    else if (x == VAL_MIN) res = VAL_MAX;
    else res = -x;
    return res;
  endfunction

endpackage

// ===== rtl/core/flight_phase_peak_stats.sv =====
// ---------------------------------------------------------------------------
// flight_phase_peak_stats - flight phase tracker with per-phase extremes
// Tracks the phase from events and ticks, keeps peak statistics per phase
// and sends each finished phase record out as a run of field words.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | action, now_ms, value_a/b/c
//  out_    | output    | out_valid / out_stall| record_kind, field_index,
//          |           |                      | field_value, last_of_record
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an input word is held in the input register and updates the state from
// there, so one word per cycle is taken while in_stall is low; a word that
// closes a phase copies its record into the output buffer, which then sends
// one field per cycle while out_stall is low; a second closing word waits in
// the input register until the buffer's last field is taken. rst_n is
// synchronous; cfg_ready is always high.
// ---------------------------------------------------------------------------
module flight_phase_peak_stats (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [3:0]                         in_action,
  input  logic [31:0]                        in_now_ms,
  input  logic signed [flps_pkg::VAL_W-1:0]  in_value_a,
  input  logic signed [flps_pkg::VAL_W-1:0]  in_value_b,
  input  logic signed [flps_pkg::VAL_W-1:0]  in_value_c,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_record_kind,
  output logic [2:0]                         out_field_index,
  output logic signed [flps_pkg::VAL_W-1:0]  out_field_value,
  output logic                               out_last_of_record,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [flps_pkg::CFG_W-1:0]         cfg_data
);

  localparam int TB = flps_pkg::TIME_BITS;
  localparam int VW = flps_pkg::VAL_W;
  localparam int CW = flps_pkg::CMP_W;

  // input register
  logic                 item_vld_r, item_vld_nxt;
  logic [3:0]           act_r;
  logic [31:0]          now_r;
  logic signed [VW-1:0] a_r, b_r, c_r;

  // configuration
  logic [flps_pkg::CFG_W-1:0] lto_r, dto_r, mto_r;

  // tracker state
  flps_pkg::phase_t     phase_r, phase_nxt;
  logic [TB-1:0]        entry_r, entry_nxt;
  logic                 pend_r, pend_nxt;
  logic                 latch_r, latch_nxt;
  logic signed [VW-1:0] lr_r [6];
  logic signed [VW-1:0] lr_nxt [6];
  logic signed [VW-1:0] ar_r [8];
  logic signed [VW-1:0] ar_nxt [8];
  logic signed [VW-1:0] dr_r [2];
  logic signed [VW-1:0] dr_nxt [2];
  logic signed [VW-1:0] mr_r [4];
  logic signed [VW-1:0] mr_nxt [4];

  // output buffer
  logic                  busy_r, busy_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic [2:0]            last_r, last_nxt;
  flps_pkg::rec_kind_t   kind_r, kind_nxt;
  logic signed [VW-1:0]  buf_r [8];
  logic signed [VW-1:0]  buf_nxt [8];

  logic                  accept, proceed, emit, out_take, buf_free;
  flps_pkg::rec_kind_t   emit_kind;
  logic [TB-1:0]         now_t, elapsed;
  logic signed [VW-1:0]  now_v, acc_mag;
  logic                  lto_hit, dto_hit, mto_hit;

  assign now_t   = TB'(now_r);
  assign now_v   = VW'(now_t);
  assign elapsed = now_t - entry_r;
  assign lto_hit = CW'(elapsed) >= CW'(lto_r);
  assign dto_hit = CW'(elapsed) >= CW'(dto_r);
  assign mto_hit = CW'(elapsed) >= CW'(mto_r);
  assign acc_mag = flps_pkg::mag(a_r);

  // does the held word close a phase
  always_comb begin
    emit      = 1'b0;
    emit_kind = flps_pkg::REC_LIFTOFF;
    case (act_r)
      flps_pkg::ACT_TICK: begin
        if (phase_r == flps_pkg::PH_LIFTOFF && lto_hit) begin
          emit      = 1'b1;
          emit_kind = flps_pkg::REC_LIFTOFF;
        end else if (phase_r == flps_pkg::PH_DROGUE && dto_hit) begin
          emit      = 1'b1;
          emit_kind = flps_pkg::REC_DROGUE;
        end else if (phase_r == flps_pkg::PH_MAIN && mto_hit) begin
          emit      = 1'b1;
          emit_kind = flps_pkg::REC_MAIN;
        end
      end
      flps_pkg::ACT_APOGEE: begin
        if (phase_r == flps_pkg::PH_ASCEND) begin
          emit      = 1'b1;
          emit_kind = flps_pkg::REC_APOGEE;
        end
      end
      default: ;
    endcase
  end

  assign out_take = busy_r && !out_stall;
  assign buf_free = !busy_r || (out_take && idx_r == last_r);
  assign proceed  = item_vld_r && (!emit || buf_free);
  assign in_stall = item_vld_r && !proceed;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign item_vld_nxt = accept ? 1'b1 : (proceed ? 1'b0 : item_vld_r);

  // state update for the held word
  always_comb begin
    phase_nxt = phase_r;
    entry_nxt = entry_r;
    pend_nxt  = pend_r;
    latch_nxt = latch_r;
    lr_nxt    = lr_r;
    ar_nxt    = ar_r;
    dr_nxt    = dr_r;
    mr_nxt    = mr_r;
    if (proceed) begin
      case (act_r)
        flps_pkg::ACT_TICK: begin
          if (emit) begin
            entry_nxt = now_t;
            if (phase_r == flps_pkg::PH_LIFTOFF) begin
              phase_nxt = flps_pkg::PH_ASCEND;
            end else if (pend_r) begin
              // deploy seen during drogue: straight from drogue into main, skipping idle
              pend_nxt  = 1'b0;
              phase_nxt = flps_pkg::PH_MAIN;
              mr_nxt[0] = now_v;
            end else begin
              phase_nxt = flps_pkg::PH_IDLE;
            end
          end
        end
        flps_pkg::ACT_LIFTOFF: begin
          if (phase_r == flps_pkg::PH_IDLE) begin
            phase_nxt = flps_pkg::PH_LIFTOFF;
            entry_nxt = now_t;
            lr_nxt[0] = now_v;
          end
        end
        flps_pkg::ACT_APOGEE: begin
          if (phase_r == flps_pkg::PH_ASCEND) begin
            ar_nxt[0] = now_v;
            phase_nxt = flps_pkg::PH_DROGUE;
            entry_nxt = now_t;
          end
        end
        flps_pkg::ACT_DEPLOY_ALT: begin
          if (phase_r == flps_pkg::PH_IDLE) begin
            phase_nxt = flps_pkg::PH_MAIN;
            entry_nxt = now_t;
            mr_nxt[0] = now_v;
          end else if (phase_r == flps_pkg::PH_DROGUE) begin
            pend_nxt = 1'b1;
          end
        end
        flps_pkg::ACT_FILT_PRESS: begin
          if (phase_r == flps_pkg::PH_ASCEND && a_r < ar_r[1]) ar_nxt[1] = a_r;
        end
        flps_pkg::ACT_FILT_ALT: begin
          if (phase_r == flps_pkg::PH_LIFTOFF) begin
            if (b_r > lr_r[4]) begin
              lr_nxt[4] = b_r;
              lr_nxt[3] = now_v;
              lr_nxt[5] = a_r;
            end
          end else if (phase_r == flps_pkg::PH_ASCEND) begin
            if (a_r > ar_r[4]) ar_nxt[4] = a_r;
          end else if (phase_r == flps_pkg::PH_MAIN && !latch_r) begin
            mr_nxt[2] = a_r;
            mr_nxt[3] = b_r;
            latch_nxt = 1'b1;
          end
        end
        flps_pkg::ACT_BARO_PAIR: begin
          if (phase_r == flps_pkg::PH_ASCEND) begin
            if (a_r < ar_r[2]) ar_nxt[2] = a_r;
            if (b_r < ar_r[3]) ar_nxt[3] = b_r;
          end
        end
        flps_pkg::ACT_ACCEL_Z: begin
          if (phase_r == flps_pkg::PH_LIFTOFF) begin
            if (acc_mag > lr_r[2]) begin
              lr_nxt[2] = acc_mag;
              lr_nxt[1] = now_v;
            end
          end else if (phase_r == flps_pkg::PH_DROGUE) begin
            if (acc_mag > dr_r[1]) begin
              dr_nxt[1] = acc_mag;
              dr_nxt[0] = now_v;
            end
          end else if (phase_r == flps_pkg::PH_MAIN) begin
            if (acc_mag > mr_r[1]) mr_nxt[1] = acc_mag;
          end
        end
        flps_pkg::ACT_GPS: begin
          if (phase_r == flps_pkg::PH_ASCEND && a_r > ar_r[5]) begin
            ar_nxt[5] = a_r;
            ar_nxt[6] = b_r;
            ar_nxt[7] = c_r;
          end
        end
        default: ;
      endcase
    end
  end

  // output buffer: snapshot of the closing record, then one field per cycle while out_stall is low
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    kind_nxt = kind_r;
    buf_nxt  = buf_r;
    if (proceed && emit) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
      kind_nxt = emit_kind;
      for (int i = 0; i < 8; i++) buf_nxt[i] = '0;
      unique case (emit_kind)
        flps_pkg::REC_LIFTOFF: begin
          last_nxt = flps_pkg::LAST_LIFTOFF;
          for (int i = 0; i < 6; i++) buf_nxt[i] = lr_r[i];
        end
        flps_pkg::REC_APOGEE: begin
          last_nxt = flps_pkg::LAST_APOGEE;
          buf_nxt[0] = now_v;
          for (int i = 1; i < 8; i++) buf_nxt[i] = ar_r[i];
        end
        flps_pkg::REC_DROGUE: begin
          last_nxt = flps_pkg::LAST_DROGUE;
          for (int i = 0; i < 2; i++) buf_nxt[i] = dr_r[i];
        end
        flps_pkg::REC_MAIN: begin
          last_nxt = flps_pkg::LAST_MAIN;
          for (int i = 0; i < 4; i++) buf_nxt[i] = mr_r[i];
        end
        default: ;
      endcase
    end else if (out_take) begin
      if (idx_r == last_r) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 3'd1;
    end
  end

  assign out_valid          = busy_r;
  assign out_record_kind    = kind_r;
  assign out_field_index    = idx_r;
  assign out_field_value    = buf_r[idx_r];
  assign out_last_of_record = (idx_r == last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      busy_r     <= 1'b0;
      idx_r      <= '0;
      last_r     <= '0;
      kind_r     <= flps_pkg::REC_LIFTOFF;
      phase_r    <= flps_pkg::PH_IDLE;
      entry_r    <= '0;
      pend_r     <= 1'b0;
      latch_r    <= 1'b0;
      lto_r      <= flps_pkg::CFG_W'(10000);
      dto_r      <= flps_pkg::CFG_W'(10000);
      mto_r      <= flps_pkg::CFG_W'(10000);
      for (int i = 0; i < 6; i++) lr_r[i] <= '0;
      for (int i = 0; i < 2; i++) dr_r[i] <= '0;
      for (int i = 0; i < 4; i++) mr_r[i] <= '0;
      ar_r[0] <= '0;
      ar_r[1] <= flps_pkg::VAL_MAX;
      ar_r[2] <= flps_pkg::VAL_MAX;
      ar_r[3] <= flps_pkg::VAL_MAX;
      for (int i = 4; i < 8; i++) ar_r[i] <= flps_pkg::VAL_MIN;
    end else begin
      item_vld_r <= item_vld_nxt;
      busy_r     <= busy_nxt;
      idx_r      <= idx_nxt;
      last_r     <= last_nxt;
      kind_r     <= kind_nxt;
      phase_r    <= phase_nxt;
      entry_r    <= entry_nxt;
      pend_r     <= pend_nxt;
      latch_r    <= latch_nxt;
      lr_r       <= lr_nxt;
      ar_r       <= ar_nxt;
      dr_r       <= dr_nxt;
      mr_r       <= mr_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          flps_pkg::CFG_LIFTOFF_TO: lto_r <= cfg_data;
          flps_pkg::CFG_DROGUE_TO:  dto_r <= cfg_data;
          flps_pkg::CFG_MAIN_TO:    mto_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      now_r <= in_now_ms;
      a_r   <= in_value_a;
      b_r   <= in_value_b;
      c_r   <= in_value_c;
    end
    buf_r <= buf_nxt;
  end

endmodule
